[src/lofi_lowpass_quantizer_macros.svh]
// Assertion macros shared by the lowpass quantizer RTL
`ifndef LOFI_LOWPASS_QUANTIZER_MACROS_SVH
`define LOFI_LOWPASS_QUANTIZER_MACROS_SVH

// plain property, checked on every clock outside reset
`define LOFI_CHECK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lofi check failed");

// condition in one cycle implies outcome in the next
`define LOFI_CHECK_NEXT(label, cond, nxt) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error("lofi sequence check failed");

`endif

[src/lofi_pkg.sv]
// Shared types and constants for the lowpass quantizer
`default_nettype none
package lofi_pkg;

  localparam logic [1:0] QM_STD  = 2'd0;
  localparam logic [1:0] QM_LONG = 2'd1;
  localparam logic [1:0] QM_LOFI = 2'd2;

  localparam logic CFG_QUALITY = 1'b0;
  localparam logic CFG_STEREO  = 1'b1;

  localparam logic signed [14:0] ALPHA_LONG = 15'sd13107;
  localparam logic signed [14:0] ALPHA_LOFI = 15'sd5243;

  localparam int unsigned BITS_LONG   = 12;
  localparam int unsigned BITS_LOFI   = 8;
  localparam int unsigned LEVELS_LONG = (1 << BITS_LONG) - 1;
  localparam int unsigned LEVELS_LOFI = (1 << BITS_LOFI) - 1;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam int unsigned RECIP_LONG  = (1 << RECIP_SHIFT) / (2 * LEVELS_LONG);
  localparam int unsigned RECIP_LOFI  = (1 << RECIP_SHIFT) / (2 * LEVELS_LOFI);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_KQ,
    ST_EST,
    ST_FIN
  } lofi_state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic mul;
    logic upd;
    logic kq;
    logic est;
    logic filt;
    logic lofi;
  } lofi_ctl_t;

endpackage
`default_nettype wire

[src/lofi_lane.sv]
// One channel lane: one-pole lowpass, requantizer and bypass saturation
`default_nettype none
module lofi_lane (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lofi_pkg::lofi_ctl_t     ctl_i,
  input  logic                    lane_en_i,
  input  logic signed [16:0]      sample_i,
  output logic signed [15:0]      result_o
);
  import lofi_pkg::*;

  logic signed [16:0] x_r;
  logic signed [16:0] hist_r;
  logic signed [32:0] prod_r;
  logic signed [16:0] lp_r;
  logic        [11:0] k_r;
  logic        [16:0] est_r;

  logic signed [17:0] diff;
  logic signed [14:0] alpha;
  logic signed [32:0] prod_nxt;
  logic signed [33:0] rnd;
  logic signed [17:0] delta;
  logic signed [18:0] lp_wide;
  logic signed [16:0] lp_nxt;
  logic signed [16:0] clip;
  logic signed [17:0] vs;
  logic        [16:0] v;
  logic        [29:0] vl;
  logic        [29:0] ksum;
  logic        [28:0] num;
  logic        [21:0] recip;
  logic        [50:0] est_prod;
  logic        [30:0] est_d;
  logic        [30:0] rem;
  logic        [30:0] dval;
  logic        [17:0] q;
  logic signed [15:0] quant;
  logic signed [15:0] bypass;

  assign diff     = {x_r[16], x_r} - {hist_r[16], hist_r};
  assign alpha    = ctl_i.lofi ? ALPHA_LOFI : ALPHA_LONG;
  assign prod_nxt = diff * alpha;

  assign rnd     = {prod_r[32], prod_r} + 34'sd32768;
  assign delta   = rnd[33:16];
  assign lp_wide = {{2{hist_r[16]}}, hist_r} + {delta[17], delta};

  always_comb begin
    if (lp_wide > 19'sd65535) begin
      lp_nxt = 17'sd65535;
    end else if (lp_wide < -19'sd65536) begin
      lp_nxt = -17'sd65536;
    end else begin
      lp_nxt = lp_wide[16:0];
    end
  end

  always_comb begin
    if (lp_r > 17'sd32768) begin
      clip = 17'sd32768;
    end else if (lp_r < -17'sd32768) begin
      clip = -17'sd32768;
    end else begin
      clip = lp_r;
    end
  end

  assign vs   = {clip[16], clip} + 18'sd32768;
  assign v    = vs[16:0];
  assign vl   = ctl_i.lofi ? ({5'b0, v, 8'b0} - {13'b0, v})
                           : ({1'b0, v, 12'b0} - {13'b0, v});
  assign ksum = vl + 30'd32768;

  // numerator 2*k*65536 + levels, divided by 2*levels via reciprocal
  assign num      = {k_r, 17'b0} + (ctl_i.lofi ? 29'(LEVELS_LOFI) : 29'(LEVELS_LONG));
  assign recip    = ctl_i.lofi ? 22'(RECIP_LOFI) : 22'(RECIP_LONG);
  assign est_prod = 51'(num) * 51'(recip);

  assign est_d = ctl_i.lofi ? ({5'b0, est_r, 9'b0} - {13'b0, est_r, 1'b0})
                            : ({1'b0, est_r, 13'b0} - {13'b0, est_r, 1'b0});
  assign rem   = {2'b0, num} - est_d;
  assign dval  = ctl_i.lofi ? 31'(2 * LEVELS_LOFI) : 31'(2 * LEVELS_LONG);
  assign q     = {1'b0, est_r} + {17'b0, (rem >= dval)};

  always_comb begin
    if (q[17:16] != 2'b00) begin
      quant = 16'sd32767;
    end else begin
      quant = {~q[15], q[14:0]};
    end
  end

  always_comb begin
    if (x_r > 17'sd32767) begin
      bypass = 16'sd32767;
    end else if (x_r < -17'sd32768) begin
      bypass = -16'sd32768;
    end else begin
      bypass = x_r[15:0];
    end
  end

  assign result_o = ctl_i.filt ? quant : bypass;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else if (ctl_i.load && ctl_i.clear) begin
      hist_r <= '0;
    end else if (ctl_i.upd && ctl_i.filt && lane_en_i) begin
      hist_r <= lp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.load) begin
      x_r <= sample_i;
    end
    if (ctl_i.mul) begin
      prod_r <= prod_nxt;
    end
    if (ctl_i.upd) begin
      lp_r <= lp_nxt;
    end
    if (ctl_i.kq) begin
      k_r <= ksum[27:16];
    end
    if (ctl_i.est) begin
      est_r <= est_prod[46:30];
    end
  end

endmodule
`default_nettype wire

[src/lofi_merge.sv]
// Merging stage: combines the lane results into the registered output word
`default_nettype none
module lofi_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take_i,
  input  logic               stereo_i,
  input  logic               last_i,
  input  logic signed [15:0] left_i,
  input  logic signed [15:0] right_i,
  output logic               space_o,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_left_out,
  output logic signed [15:0] out_right_out,
  output logic               out_end_of_take
);

  logic               valid_r;
  logic signed [15:0] left_r;
  logic signed [15:0] right_r;
  logic               eot_r;

  assign space_o = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take_i) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // mono: right word is forced to zero
  always_ff @(posedge clk) begin
    if (take_i) begin
      left_r  <= left_i;
      right_r <= stereo_i ? right_i : 16'sd0;
      eot_r   <= last_i;
    end
  end

  assign out_valid       = valid_r;
  assign out_left_out    = left_r;
  assign out_right_out   = right_r;
  assign out_end_of_take = eot_r;

endmodule
`default_nettype wire

[src/lofi_lowpass_quantizer.sv]
// Top level of the lowpass quantizer: control sequencer, config, two lanes, merge
//
// Input channel (in_valid/in_ready) takes one frame word: left and right Q2.15
// samples plus first and last marks. Output channel (out_valid/out_ready)
// returns one word per frame: left and right Q1.15 and the end-of-take mark.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 quality mode,
// index 1 stereo mode; write only while no frame is in flight.
// Both lanes run side by side; the sequencer steps them together.
// Standard quality: steps accept and finish.
// Long and lo-fi: steps accept, filter multiply, history update, level
// scaling, reciprocal multiply and rounding fix-up, in that order.
// Each frame is handed to the output register only when it has space, and a
// new frame is accepted only after that handoff.
// The output register lets the next frame be accepted while a result waits;
// if the receiver stalls, the finished frame is held in the lanes until the
// output register frees.
// Reset clears the config to standard mono, the filter histories and the
// output valid flag.
`default_nettype none
`include "lofi_lowpass_quantizer_macros.svh"
module lofi_lowpass_quantizer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [16:0] in_left_sample,
  input  logic signed [16:0] in_right_sample,
  input  logic               in_first_frame,
  input  logic               in_last_frame,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_left_out,
  output logic signed [15:0] out_right_out,
  output logic               out_end_of_take,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [1:0]         cfg_data
);
  import lofi_pkg::*;

  logic [1:0]         quality_r;
  logic               stereo_r;
  lofi_state_t        state_r;
  lofi_state_t        state_nxt;
  logic               last_r;
  lofi_ctl_t          ctl;
  logic               take;
  logic               space;
  logic               filt;
  logic signed [15:0] left_res;
  logic signed [15:0] right_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quality_r <= QM_STD;
      stereo_r  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_QUALITY: quality_r <= cfg_data;
        CFG_STEREO:  stereo_r  <= cfg_data[0];
        default:     stereo_r  <= stereo_r;
      endcase
    end
  end

  assign filt = (quality_r == QM_LONG) || (quality_r == QM_LOFI);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      last_r <= in_last_frame;
    end
  end

  always_comb begin
    ctl       = '0;
    ctl.filt  = filt;
    ctl.lofi  = (quality_r == QM_LOFI);
    in_ready  = 1'b0;
    take      = 1'b0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load  = 1'b1;
          ctl.clear = in_first_frame;
          state_nxt = filt ? ST_MUL : ST_FIN;
        end
      end
      ST_MUL: begin
        ctl.mul   = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        ctl.upd   = 1'b1;
        state_nxt = ST_KQ;
      end
      ST_KQ: begin
        ctl.kq    = 1'b1;
        state_nxt = ST_EST;
      end
      ST_EST: begin
        ctl.est   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (space) begin
          take      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  lofi_lane u_lane_left (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (ctl),
    .lane_en_i (1'b1),
    .sample_i  (in_left_sample),
    .result_o  (left_res)
  );

  lofi_lane u_lane_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (ctl),
    .lane_en_i (stereo_r),
    .sample_i  (in_right_sample),
    .result_o  (right_res)
  );

  lofi_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .take_i          (take),
    .stereo_i        (stereo_r),
    .last_i          (last_r),
    .left_i          (left_res),
    .right_i         (right_res),
    .space_o         (space),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_left_out    (out_left_out),
    .out_right_out   (out_right_out),
    .out_end_of_take (out_end_of_take)
  );

  `LOFI_CHECK(a_out_from_fin, $rose(out_valid) |-> $past(state_r == ST_FIN))
  `LOFI_CHECK_NEXT(a_fin_hold, (state_r == ST_FIN) && out_valid && !out_ready, state_r == ST_FIN)
  `LOFI_CHECK_NEXT(a_accept_filt, in_valid && in_ready && filt, state_r == ST_MUL)
  `LOFI_CHECK_NEXT(a_accept_bypass, in_valid && in_ready && !filt, state_r == ST_FIN)

endmodule
`default_nettype wire
